// File: design/ndec_pkg.sv
`timescale 1ns / 1ps

package ndec_pkg;

  // Defaults for the top-level parameters
  localparam int BRIGHTNESS_BITS_DEF   = 4;
  localparam int PWM_PERIOD_US_DEF     = 1024;
  localparam int SCROLL_STEP_MS_DEF    = 40;
  localparam int DIM_STEP_MS_DEF       = 32;
  localparam int BLINK_PERIOD_MS_DEF   = 1024;
  localparam int BLINK_DIM_STEP_MS_DEF = 16;

  localparam logic [4:0] BRIGHT_RESET = 5'd16;
  localparam logic [3:0] BLANK_DIGIT  = 4'd10;
  localparam logic [3:0] DIGIT_MAX    = 4'd9;
  localparam logic [3:0] SCROLL_COUNT = 4'd10;

  // Command codes
  localparam logic [3:0] MODE_TICK       = 4'd0;
  localparam logic [3:0] MODE_SMOOTH_ON  = 4'd1;
  localparam logic [3:0] MODE_SMOOTH_OFF = 4'd2;
  localparam logic [3:0] MODE_BLINK      = 4'd3;
  localparam logic [3:0] MODE_NO_BLINK   = 4'd4;
  localparam logic [3:0] MODE_SCROLL_ON  = 4'd5;
  localparam logic [3:0] MODE_SCROLL_OFF = 4'd6;
  localparam logic [3:0] MODE_SCROLL_FWD = 4'd7;
  localparam logic [3:0] MODE_SCROLL_BK  = 4'd8;
  localparam logic [3:0] MODE_ANODE_ON   = 4'd9;
  localparam logic [3:0] MODE_SET_VALUE  = 4'd10;

  // Effect state codes; codes above ST_SCROLL_ON can be loaded via next_state
  localparam logic [3:0] ST_OFF         = 4'd0;
  localparam logic [3:0] ST_SMOOTH_OFF  = 4'd1;
  localparam logic [3:0] ST_SMOOTH_ON   = 4'd2;
  localparam logic [3:0] ST_NORMAL      = 4'd3;
  localparam logic [3:0] ST_BLINK_ON    = 4'd4;
  localparam logic [3:0] ST_BLINK_OFF   = 4'd5;
  localparam logic [3:0] ST_SCROLL_OFF  = 4'd6;
  localparam logic [3:0] ST_SCROLL_FWD  = 4'd7;
  localparam logic [3:0] ST_SCROLL_BACK = 4'd8;
  localparam logic [3:0] ST_SCROLL_ON   = 4'd9;

  typedef struct packed {
    logic [3:0]  mode;
    logic [15:0] now_us;
    logic [15:0] now_ms;
    logic [3:0]  digit_value;
    logic [15:0] delay_ms;
    logic        use_default_delay;
    logic [3:0]  next_state;
  } item_t;

  typedef struct packed {
    logic [3:0]  effect_state;
    logic [3:0]  after_scroll;
    logic [3:0]  shown_digit;
    logic [3:0]  target_digit;
    logic        enabled_flag;
    logic [4:0]  ramp_level;
    logic [15:0] pulse_width;
    logic [15:0] pwm_stamp;
    logic [15:0] scroll_stamp;
    logic [15:0] dim_stamp;
    logic [3:0]  scroll_delay_count;
    logic        anode_level;
  } state_t;

endpackage

// File: design/ndec_step.sv
`timescale 1ns / 1ps

module ndec_step #(
  parameter int BRIGHTNESS_BITS   = ndec_pkg::BRIGHTNESS_BITS_DEF,
  parameter int PWM_PERIOD_US     = ndec_pkg::PWM_PERIOD_US_DEF,
  parameter int SCROLL_STEP_MS    = ndec_pkg::SCROLL_STEP_MS_DEF,
  parameter int DIM_STEP_MS       = ndec_pkg::DIM_STEP_MS_DEF,
  parameter int BLINK_PERIOD_MS   = ndec_pkg::BLINK_PERIOD_MS_DEF,
  parameter int BLINK_DIM_STEP_MS = ndec_pkg::BLINK_DIM_STEP_MS_DEF
) (
  input  ndec_pkg::item_t  item,
  input  ndec_pkg::state_t state_cur,
  input  logic [4:0]       max_brightness,
  output ndec_pkg::state_t state_next,
  output logic             stepped
);

  localparam logic [15:0] PWM_W      = 16'(PWM_PERIOD_US);
  localparam logic [15:0] SCROLL_W   = 16'(SCROLL_STEP_MS);
  localparam logic [15:0] DIM_W      = 16'(DIM_STEP_MS);
  localparam logic [15:0] BDIM_W     = 16'(BLINK_DIM_STEP_MS);
  localparam logic [15:0] PHASE_MASK = 16'(BLINK_PERIOD_MS - 1);
  localparam logic [15:0] HALF_W     = 16'(BLINK_PERIOD_MS / 2);

  // Level to pulse width: constant multiply, shift, clamp at full period
  function automatic ndec_pkg::state_t set_level(ndec_pkg::state_t s, logic [4:0] b);
    logic [21:0] w;
    w = (22'(PWM_PERIOD_US) * 22'(b)) >> BRIGHTNESS_BITS;
    s.ramp_level = b;
    s.pulse_width = (w > 22'(PWM_PERIOD_US)) ? PWM_W : w[15:0];
    return s;
  endfunction

  function automatic ndec_pkg::state_t ramp_normal(ndec_pkg::state_t s, logic [15:0] ms,
                                                   logic [4:0] maxb);
    logic [15:0] dt;
    dt = ms - s.dim_stamp;
    if (dt >= DIM_W) begin
      s.dim_stamp = s.dim_stamp + DIM_W;
      if (s.effect_state == ndec_pkg::ST_SMOOTH_OFF ||
          s.effect_state == ndec_pkg::ST_SCROLL_OFF) begin
        if (s.ramp_level != 5'd0) s = set_level(s, s.ramp_level - 5'd1);
      end else if (s.ramp_level != maxb) begin
        s = set_level(s, (s.ramp_level < maxb) ? s.ramp_level + 5'd1
                                               : s.ramp_level - 5'd1);
      end
    end
    return s;
  endfunction

  function automatic ndec_pkg::state_t ramp_blink(ndec_pkg::state_t s, logic [15:0] ms,
                                                  logic [4:0] maxb);
    logic [15:0] dt;
    dt = ms - s.dim_stamp;
    if (dt >= BDIM_W) begin
      s.dim_stamp = s.dim_stamp + BDIM_W;
      if (s.effect_state == ndec_pkg::ST_BLINK_ON) begin
        if (s.ramp_level < maxb) s = set_level(s, s.ramp_level + 5'd1);
      end else if (s.ramp_level != 5'd0) begin
        s = set_level(s, s.ramp_level - 5'd1);
      end
    end
    return s;
  endfunction

  function automatic ndec_pkg::state_t start_scroll(ndec_pkg::state_t s, logic [3:0] st,
                                                    logic [3:0] nxt, logic [15:0] ms);
    s.effect_state = st;
    s.enabled_flag = 1'b1;
    s.dim_stamp = ms;
    s.scroll_delay_count = ndec_pkg::SCROLL_COUNT;
    s.after_scroll = nxt;
    s.shown_digit = s.target_digit;
    s.scroll_stamp = ms;
    return s;
  endfunction

  function automatic ndec_pkg::state_t refresh_dim(ndec_pkg::state_t s, logic [15:0] ms,
                                                   logic [15:0] step);
    logic [15:0] dt;
    dt = ms - s.dim_stamp;
    if ({1'b0, dt} >= {step, 1'b0}) s.dim_stamp = ms;
    return s;
  endfunction

  function automatic logic [3:0] digit_up(logic [3:0] d);
    return (d >= ndec_pkg::DIGIT_MAX) ? 4'd0 : d + 4'd1;
  endfunction

  function automatic logic [3:0] digit_down(logic [3:0] d);
    return (d == 4'd0 || d > ndec_pkg::DIGIT_MAX) ? ndec_pkg::DIGIT_MAX : d - 4'd1;
  endfunction

  function automatic ndec_pkg::state_t run_step(ndec_pkg::state_t s, logic [15:0] ms,
                                                logic [4:0] maxb);
    logic [15:0] delta;
    logic [15:0] phase;
    logic        fwd;
    phase = ms & PHASE_MASK;
    delta = ms - s.scroll_stamp;
    fwd   = (s.effect_state == ndec_pkg::ST_SCROLL_FWD);
    case (s.effect_state)
      ndec_pkg::ST_OFF: begin
      end
      ndec_pkg::ST_SMOOTH_OFF: begin
        if (s.ramp_level == 5'd0) begin
          s.effect_state = ndec_pkg::ST_OFF;
          s.enabled_flag = 1'b0;
        end else begin
          s = ramp_normal(s, ms, maxb);
        end
      end
      ndec_pkg::ST_SMOOTH_ON, ndec_pkg::ST_NORMAL: begin
        s.shown_digit = s.target_digit;
        s = ramp_normal(s, ms, maxb);
      end
      ndec_pkg::ST_BLINK_ON: begin
        if (phase <= HALF_W) s.effect_state = ndec_pkg::ST_BLINK_OFF;
        s.shown_digit = s.target_digit;
        s = ramp_blink(s, ms, maxb);
      end
      ndec_pkg::ST_BLINK_OFF: begin
        if (s.ramp_level == 5'd0) s.enabled_flag = 1'b0;
        if (phase > HALF_W) begin
          s.effect_state = ndec_pkg::ST_BLINK_ON;
          s.enabled_flag = 1'b1;
        end
        s = ramp_blink(s, ms, maxb);
      end
      ndec_pkg::ST_SCROLL_OFF: begin
        if (delta >= SCROLL_W) begin
          s.scroll_stamp = s.scroll_stamp + SCROLL_W;
          s.shown_digit = digit_up(s.shown_digit);
        end
        if (s.scroll_delay_count != 4'd0) begin
          if (delta >= SCROLL_W) begin
            if (delta < s.dim_stamp) begin
              s.dim_stamp = s.dim_stamp - delta;
            end else begin
              s.scroll_stamp = ms;
              s.dim_stamp = ms;
              s.scroll_delay_count = 4'd0;
            end
          end
        end else begin
          s = ramp_normal(s, ms, maxb);
          if (s.ramp_level == 5'd0) begin
            s.effect_state = s.after_scroll;
            s.enabled_flag = 1'b0;
          end
        end
      end
      ndec_pkg::ST_SCROLL_FWD, ndec_pkg::ST_SCROLL_BACK: begin
        if (delta >= SCROLL_W) begin
          s.scroll_stamp = s.scroll_stamp + SCROLL_W;
          if (s.scroll_delay_count != 4'd0) s.scroll_delay_count = s.scroll_delay_count - 4'd1;
          s.shown_digit = fwd ? digit_up(s.shown_digit) : digit_down(s.shown_digit);
          if (s.shown_digit == s.target_digit && s.scroll_delay_count == 4'd0) begin
            if (fwd) s.scroll_stamp = ms;
            s.effect_state = s.after_scroll;
          end
        end
        // ramp sees the state left by a completed scroll
        s = ramp_normal(s, ms, maxb);
      end
      ndec_pkg::ST_SCROLL_ON: begin
        if (delta < s.dim_stamp) begin
          s.dim_stamp = s.dim_stamp - delta;
          s.scroll_stamp = ms;
        end else begin
          s = start_scroll(s, ndec_pkg::ST_SCROLL_FWD, ndec_pkg::ST_NORMAL, ms);
        end
      end
      default: begin
        s.shown_digit = ndec_pkg::BLANK_DIGIT;
      end
    endcase
    return s;
  endfunction

  always_comb begin
    ndec_pkg::state_t s;
    logic [15:0] d;
    logic [15:0] dflt_on;
    logic [15:0] dflt_off;
    s = state_cur;
    stepped = 1'b0;
    d = item.now_us - state_cur.pwm_stamp;
    dflt_on  = 16'(state_cur.target_digit) * SCROLL_W;
    dflt_off = 16'(state_cur.target_digit >> 1) * SCROLL_W;
    case (item.mode)
      ndec_pkg::MODE_TICK: begin
        if (d >= s.pulse_width) s.anode_level = 1'b0;
        if (d >= PWM_W) begin
          s.pwm_stamp = item.now_us;
          s = run_step(s, item.now_ms, max_brightness);
          stepped = 1'b1;
        end
      end
      ndec_pkg::MODE_SMOOTH_ON, ndec_pkg::MODE_NO_BLINK: begin
        s.effect_state = ndec_pkg::ST_NORMAL;
        s.enabled_flag = 1'b1;
        s = refresh_dim(s, item.now_ms, DIM_W);
      end
      ndec_pkg::MODE_SMOOTH_OFF: begin
        if (s.effect_state != ndec_pkg::ST_OFF) begin
          s.effect_state = ndec_pkg::ST_SMOOTH_OFF;
          s = refresh_dim(s, item.now_ms, DIM_W);
        end
      end
      ndec_pkg::MODE_BLINK: begin
        if (s.effect_state != ndec_pkg::ST_BLINK_ON &&
            s.effect_state != ndec_pkg::ST_BLINK_OFF) begin
          s.effect_state = ndec_pkg::ST_BLINK_ON;
          s.enabled_flag = 1'b1;
          s = refresh_dim(s, item.now_ms, BDIM_W);
        end
      end
      ndec_pkg::MODE_SCROLL_ON: begin
        if (s.effect_state == ndec_pkg::ST_OFF) begin
          s = set_level(s, 5'd0);
          s.dim_stamp = item.use_default_delay ? dflt_on : item.delay_ms;
          s.scroll_stamp = item.now_ms;
          s.effect_state = ndec_pkg::ST_SCROLL_ON;
        end else begin
          s = start_scroll(s, ndec_pkg::ST_SCROLL_FWD, ndec_pkg::ST_NORMAL, item.now_ms);
        end
      end
      ndec_pkg::MODE_SCROLL_OFF: begin
        if (s.effect_state != ndec_pkg::ST_OFF &&
            s.effect_state != ndec_pkg::ST_SCROLL_OFF) begin
          s.scroll_delay_count = 4'd1;
          s.dim_stamp = item.use_default_delay ? dflt_off : item.delay_ms;
          s.after_scroll = ndec_pkg::ST_OFF;
          s.effect_state = ndec_pkg::ST_SCROLL_OFF;
          s.scroll_stamp = item.now_ms;
        end
      end
      ndec_pkg::MODE_SCROLL_FWD: begin
        s = start_scroll(s, ndec_pkg::ST_SCROLL_FWD, item.next_state, item.now_ms);
      end
      ndec_pkg::MODE_SCROLL_BK: begin
        s = start_scroll(s, ndec_pkg::ST_SCROLL_BACK, item.next_state, item.now_ms);
      end
      ndec_pkg::MODE_ANODE_ON: begin
        s.pwm_stamp = item.now_us;
        if (s.enabled_flag && s.shown_digit <= ndec_pkg::DIGIT_MAX) s.anode_level = 1'b1;
      end
      ndec_pkg::MODE_SET_VALUE: begin
        if (item.digit_value <= ndec_pkg::DIGIT_MAX) s.target_digit = item.digit_value;
      end
      default: begin
      end
    endcase
    state_next = s;
  end

endmodule

// File: design/nixie_digit_effect_controller_top.sv
`timescale 1ns / 1ps

// Nixie digit effect controller: drives one tube digit from a stream of items.
// Input channel (s_*): one item per handshake, either a time tick (tuser mode 0)
// carrying microsecond and millisecond stamps, or an effect command (modes 1..10).
// Output channel (m_*): exactly one result item per input item, in order, with the
// shown digit, anode level, ramped brightness, effect state, enable and step flag.
// Configuration channel (cfg_*): writes max_brightness; always ready, and is
// meant to be written only while no item is in flight.
// Timing: an accepted item lands in the input register; once the result register is
// free or draining, the step logic updates the tube state and loads the result
// register, which raises m_tvalid.
// One item per cycle while m_tready is high; the state update is the only loop.
// Stall: while m_tready is low the result register holds; the input register
// still takes one more item, then s_tready drops until the result is taken.
// Reset (rst, synchronous): empties both registers, sets the effect state to off,
// brightness and max_brightness to 16, pulse width to the full PWM period and
// clears all stamps, counters and the anode.
module nixie_digit_effect_controller_top #(
  parameter int BRIGHTNESS_BITS   = ndec_pkg::BRIGHTNESS_BITS_DEF,
  parameter int PWM_PERIOD_US     = ndec_pkg::PWM_PERIOD_US_DEF,
  parameter int SCROLL_STEP_MS    = ndec_pkg::SCROLL_STEP_MS_DEF,
  parameter int DIM_STEP_MS       = ndec_pkg::DIM_STEP_MS_DEF,
  parameter int BLINK_PERIOD_MS   = ndec_pkg::BLINK_PERIOD_MS_DEF,
  parameter int BLINK_DIM_STEP_MS = ndec_pkg::BLINK_DIM_STEP_MS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // now_us[15:0], now_ms[31:16], digit_value[35:32], delay_ms[51:36],
  // use_default_delay[52], next_state[56:53], zero pad[63:57]
  input  logic [63:0] s_tdata,
  // mode[3:0]
  input  logic [3:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // digit_shown[3:0], anode_high[4], level_now[9:5], tube_state[13:10],
  // lit[14], stepped[15]
  output logic [15:0] m_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data
);

  ndec_pkg::item_t  item;
  logic             item_full;
  ndec_pkg::state_t state;
  ndec_pkg::state_t state_next;
  logic             stepped_next;
  logic [4:0]       max_brightness;
  logic             advance;

  // Step fires when an item is held and the result slot is free or draining
  assign advance   = item_full && (!m_tvalid || m_tready);
  assign s_tready  = !item_full || advance;
  assign cfg_ready = 1'b1;

  ndec_step #(
    .BRIGHTNESS_BITS  (BRIGHTNESS_BITS),
    .PWM_PERIOD_US    (PWM_PERIOD_US),
    .SCROLL_STEP_MS   (SCROLL_STEP_MS),
    .DIM_STEP_MS      (DIM_STEP_MS),
    .BLINK_PERIOD_MS  (BLINK_PERIOD_MS),
    .BLINK_DIM_STEP_MS(BLINK_DIM_STEP_MS)
  ) u_step (
    .item          (item),
    .state_cur     (state),
    .max_brightness(max_brightness),
    .state_next    (state_next),
    .stepped       (stepped_next)
  );

  // Input register: payload needs no reset
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item.mode              <= s_tuser;
      item.now_us            <= s_tdata[15:0];
      item.now_ms            <= s_tdata[31:16];
      item.digit_value       <= s_tdata[35:32];
      item.delay_ms          <= s_tdata[51:36];
      item.use_default_delay <= s_tdata[52];
      item.next_state        <= s_tdata[56:53];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_full <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      item_full <= 1'b1;
    end else if (advance) begin
      item_full <= 1'b0;
    end
  end

  // Tube state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      max_brightness           <= ndec_pkg::BRIGHT_RESET;
      state.effect_state       <= ndec_pkg::ST_OFF;
      state.after_scroll       <= ndec_pkg::ST_OFF;
      state.shown_digit        <= 4'd0;
      state.target_digit       <= 4'd0;
      state.enabled_flag       <= 1'b0;
      state.ramp_level         <= ndec_pkg::BRIGHT_RESET;
      state.pulse_width        <= 16'(PWM_PERIOD_US);
      state.pwm_stamp          <= 16'd0;
      state.scroll_stamp       <= 16'd0;
      state.dim_stamp          <= 16'd0;
      state.scroll_delay_count <= 4'd0;
      state.anode_level        <= 1'b0;
    end else begin
      if (cfg_valid) max_brightness <= cfg_data;
      if (advance) state <= state_next;
    end
  end

  // Result register: hold while the receiver stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {stepped_next, state_next.enabled_flag, state_next.effect_state,
                  state_next.ramp_level, state_next.anode_level, state_next.shown_digit};
    end
  end

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps

// Stream test of the nixie digit effect controller.
// Each item sent on the s_* channel is run through a local model of the tube
// (effect state, ramped brightness, PWM pulse width, time stamps, scroll count)
// at the edge where it is accepted, and the report it should produce is queued.
// Every report taken from the m_* channel is compared, field by field, with the
// oldest queued report. A short corner sequence comes first, then bursts of
// effect scenarios (fade in, blink, scroll, scroll on/off, anode pulses) mixed
// with raw noise, each burst under its own max_brightness setting and idling mix.
module testbench;
  import ndec_pkg::*;

  localparam int LEVEL_BITS   = BRIGHTNESS_BITS_DEF;
  localparam int PWM_US       = PWM_PERIOD_US_DEF;
  localparam int SCROLL_MS    = SCROLL_STEP_MS_DEF;
  localparam int DIM_MS       = DIM_STEP_MS_DEF;
  localparam int BLINK_MS     = BLINK_PERIOD_MS_DEF;
  localparam int BLINK_DIM_MS = BLINK_DIM_STEP_MS_DEF;
  // Cycles with no handshake at all before the run is declared hung
  localparam int QUIET_LIMIT  = 3000;

  // Report layout, highest bit first, so it overlays m_tdata directly
  typedef struct packed {
    logic       stepped;
    logic       lit;
    logic [3:0] tube_state;
    logic [4:0] level_now;
    logic       anode_high;
    logic [3:0] digit_shown;
  } tube_report_t;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata   = '0;
  logic [3:0]  s_tuser   = '0;
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [15:0] m_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [4:0]  cfg_data  = '0;

  // Tube model; initial values match the block after reset
  logic [3:0]  fx_state    = ST_OFF;
  logic [3:0]  fx_after    = ST_OFF;
  logic [3:0]  dig_shown   = 4'd0;
  logic [3:0]  dig_target  = 4'd0;
  logic        tube_en     = 1'b0;
  logic [4:0]  lvl         = BRIGHT_RESET;
  logic [15:0] pulse_us    = 16'(PWM_US);
  logic [15:0] pwm_mark    = '0;
  logic [15:0] scroll_mark = '0;
  logic [15:0] dim_mark    = '0;
  logic [3:0]  scroll_left = '0;
  logic        anode       = 1'b0;
  logic [4:0]  lvl_max     = BRIGHT_RESET;

  tube_report_t expected_reports[$];
  int          items_sent   = 0;
  int          reports_seen = 0;
  int          mismatches   = 0;
  int          tx_idle_pct  = 0;
  int          rx_idle_pct  = 0;
  int          quiet_cycles = 0;
  // Free running time base for generated items
  logic [15:0] clk_us = 16'h4000;
  logic [15:0] clk_ms = 16'h0200;

  nixie_digit_effect_controller_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Tube model
  // ---------------------------------------------------------------------------

  // Wrapping 16-bit distance between two stamps
  function automatic logic [15:0] elapsed(input logic [15:0] later, input logic [15:0] mark);
    return later - mark;
  endfunction

  // Load a brightness level and derive the pulse width, clamped to one period
  function automatic void set_lvl(input logic [4:0] b);
    int w;
    lvl = b;
    w = (PWM_US * int'(b)) >> LEVEL_BITS;
    if (w > PWM_US) w = PWM_US;
    pulse_us = 16'(w);
  endfunction

  // One fade step per DIM_MS; fading states head for zero, others for lvl_max
  function automatic void ramp_fade(input logic [15:0] ms);
    if (elapsed(ms, dim_mark) >= DIM_MS) begin
      dim_mark = dim_mark + 16'(DIM_MS);
      if (fx_state == ST_SMOOTH_OFF || fx_state == ST_SCROLL_OFF) begin
        if (lvl != 5'd0) set_lvl(lvl - 5'd1);
      end else if (lvl != lvl_max) begin
        set_lvl(lvl < lvl_max ? lvl + 5'd1 : lvl - 5'd1);
      end
    end
  endfunction

  // Blink ramps faster: up while in the on phase, down otherwise
  function automatic void ramp_blink(input logic [15:0] ms);
    if (elapsed(ms, dim_mark) >= BLINK_DIM_MS) begin
      dim_mark = dim_mark + 16'(BLINK_DIM_MS);
      if (fx_state == ST_BLINK_ON) begin
        if (lvl < lvl_max) set_lvl(lvl + 5'd1);
      end else begin
        if (lvl != 5'd0) set_lvl(lvl - 5'd1);
      end
    end
  endfunction

  function automatic void begin_scroll(input logic [3:0] st, input logic [3:0] nxt,
                                       input logic [15:0] ms);
    fx_state    = st;
    tube_en     = 1'b1;
    dim_mark    = ms;
    scroll_left = SCROLL_COUNT;
    fx_after    = nxt;
    dig_shown   = dig_target;
    scroll_mark = ms;
  endfunction

  // Restart the fade clock when it has fallen two steps or more behind
  function automatic void refresh_dim(input logic [15:0] ms, input int step);
    if (elapsed(ms, dim_mark) >= 2 * step) dim_mark = ms;
  endfunction

  function automatic logic [3:0] digit_up(input logic [3:0] d);
    return (d >= DIGIT_MAX) ? 4'd0 : d + 4'd1;
  endfunction

  // A blank digit scrolls back to nine
  function automatic logic [3:0] digit_down(input logic [3:0] d);
    return (d == 4'd0 || d > DIGIT_MAX) ? DIGIT_MAX : d - 4'd1;
  endfunction

  // One pass of the effect machine, run once per elapsed PWM period
  function automatic void step_effect(input logic [15:0] ms);
    logic [15:0] delta;
    logic        fwd;
    int          phase;
    phase = int'(ms) & (BLINK_MS - 1);
    delta = elapsed(ms, scroll_mark);
    case (fx_state)
      ST_OFF: ;
      ST_SMOOTH_OFF: begin
        if (lvl == 5'd0) begin
          fx_state = ST_OFF;
          tube_en  = 1'b0;
        end else begin
          ramp_fade(ms);
        end
      end
      ST_SMOOTH_ON, ST_NORMAL: begin
        dig_shown = dig_target;
        ramp_fade(ms);
      end
      ST_BLINK_ON: begin
        if (phase <= BLINK_MS / 2) fx_state = ST_BLINK_OFF;
        dig_shown = dig_target;
        ramp_blink(ms);
      end
      ST_BLINK_OFF: begin
        if (lvl == 5'd0) tube_en = 1'b0;
        if (phase > BLINK_MS / 2) begin
          fx_state = ST_BLINK_ON;
          tube_en  = 1'b1;
        end
        ramp_blink(ms);
      end
      ST_SCROLL_OFF: begin
        if (delta >= SCROLL_MS) begin
          scroll_mark = scroll_mark + 16'(SCROLL_MS);
          dig_shown   = digit_up(dig_shown);
        end
        // While the delay runs, dim_mark counts down the time still to wait
        if (scroll_left != 4'd0) begin
          if (delta >= SCROLL_MS) begin
            if (delta < dim_mark) begin
              dim_mark = dim_mark - delta;
            end else begin
              scroll_mark = ms;
              dim_mark    = ms;
              scroll_left = 4'd0;
            end
          end
        end else begin
          ramp_fade(ms);
          if (lvl == 5'd0) begin
            fx_state = fx_after;
            tube_en  = 1'b0;
          end
        end
      end
      ST_SCROLL_FWD, ST_SCROLL_BACK: begin
        if (delta >= SCROLL_MS) begin
          fwd         = (fx_state == ST_SCROLL_FWD);
          scroll_mark = scroll_mark + 16'(SCROLL_MS);
          if (scroll_left != 4'd0) scroll_left = scroll_left - 4'd1;
          dig_shown = fwd ? digit_up(dig_shown) : digit_down(dig_shown);
          if (dig_shown == dig_target && scroll_left == 4'd0) begin
            if (fwd) scroll_mark = ms;
            fx_state = fx_after;
          end
        end
        // The ramp sees the state the scroll may just have handed over to
        ramp_fade(ms);
      end
      ST_SCROLL_ON: begin
        if (delta < dim_mark) begin
          dim_mark    = dim_mark - delta;
          scroll_mark = ms;
        end else begin
          tube_en = 1'b1;
          begin_scroll(ST_SCROLL_FWD, ST_NORMAL, ms);
        end
      end
      // Codes past the last state blank the digit and touch nothing else
      default: dig_shown = BLANK_DIGIT;
    endcase
  endfunction

  // Apply one accepted item to the model and return the report it causes
  function automatic tube_report_t predict_report(input item_t it);
    logic [15:0]  d;
    logic [31:0]  prod;
    logic         stepped;
    tube_report_t r;
    stepped = 1'b0;
    case (it.mode)
      MODE_TICK: begin
        d = elapsed(it.now_us, pwm_mark);
        if (d >= pulse_us) anode = 1'b0;
        if (d >= PWM_US) begin
          pwm_mark = it.now_us;
          step_effect(it.now_ms);
          stepped = 1'b1;
        end
      end
      MODE_SMOOTH_ON, MODE_NO_BLINK: begin
        fx_state = ST_NORMAL;
        tube_en  = 1'b1;
        refresh_dim(it.now_ms, DIM_MS);
      end
      MODE_SMOOTH_OFF: begin
        if (fx_state != ST_OFF) begin
          fx_state = ST_SMOOTH_OFF;
          refresh_dim(it.now_ms, DIM_MS);
        end
      end
      MODE_BLINK: begin
        if (fx_state != ST_BLINK_ON && fx_state != ST_BLINK_OFF) begin
          fx_state = ST_BLINK_ON;
          tube_en  = 1'b1;
          refresh_dim(it.now_ms, BLINK_DIM_MS);
        end
      end
      MODE_SCROLL_ON: begin
        prod = 32'(dig_target) * 32'(SCROLL_MS);
        d = it.use_default_delay ? prod[15:0] : it.delay_ms;
        if (fx_state == ST_OFF) begin
          set_lvl(5'd0);
          dim_mark    = d;
          scroll_mark = it.now_ms;
          fx_state    = ST_SCROLL_ON;
        end else begin
          begin_scroll(ST_SCROLL_FWD, ST_NORMAL, it.now_ms);
        end
      end
      MODE_SCROLL_OFF: begin
        prod = 32'(dig_target >> 1) * 32'(SCROLL_MS);
        d = it.use_default_delay ? prod[15:0] : it.delay_ms;
        if (fx_state != ST_OFF && fx_state != ST_SCROLL_OFF) begin
          scroll_left = 4'd1;
          dim_mark    = d;
          fx_after    = ST_OFF;
          fx_state    = ST_SCROLL_OFF;
          scroll_mark = it.now_ms;
        end
      end
      MODE_SCROLL_FWD: begin_scroll(ST_SCROLL_FWD, it.next_state, it.now_ms);
      MODE_SCROLL_BK:  begin_scroll(ST_SCROLL_BACK, it.next_state, it.now_ms);
      MODE_ANODE_ON: begin
        // The period restarts even when the anode is not allowed to rise
        pwm_mark = it.now_us;
        if (!anode && tube_en && dig_shown <= DIGIT_MAX) anode = 1'b1;
      end
      MODE_SET_VALUE: begin
        if (it.digit_value <= DIGIT_MAX) dig_target = it.digit_value;
      end
      default: ;
    endcase
    r.digit_shown = dig_shown;
    r.anode_high  = anode;
    r.level_now   = lvl;
    r.tube_state  = fx_state;
    r.lit         = tube_en;
    r.stepped     = stepped;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Drive one item, idle first at random, and model it at the accepting edge.
  // Valid stays high between back-to-back items; it drops only while idling.
  task automatic send_item(input item_t it);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= it.mode;
    s_tdata  <= {7'd0, it.next_state, it.use_default_delay, it.delay_ms,
                 it.digit_value, it.now_ms, it.now_us};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expected_reports.push_back(predict_report(it));
    items_sent++;
  endtask

  // Drop valid, wait for every queued report, then let the pipeline drain
  task automatic settle_pipeline();
    s_tvalid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_max_level(input logic [4:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    lvl_max = value;
  endtask

  // Item with fixed stamps and all other fields cleared
  function automatic item_t corner_item(input logic [3:0] mode, input logic [15:0] us,
                                        input logic [15:0] ms);
    item_t it;
    it = '0;
    it.mode   = mode;
    it.now_us = us;
    it.now_ms = ms;
    return it;
  endfunction

  // Item stamped from the running time base; ticks advance time, mostly by
  // about one PWM period and a few tens of ms, now and then by a random jump
  function automatic item_t timed_item(input logic [3:0] mode);
    item_t it;
    if (mode == MODE_TICK) begin
      if ($urandom_range(99) < 3) begin
        clk_us = 16'($urandom);
        clk_ms = 16'($urandom);
      end else begin
        clk_us = clk_us + 16'($urandom_range(0, 2100));
        clk_ms = clk_ms + 16'($urandom_range(0, 56));
      end
    end else begin
      clk_us = clk_us + 16'($urandom_range(0, 40));
    end
    it.mode              = mode;
    it.now_us            = clk_us;
    it.now_ms            = clk_ms;
    it.digit_value       = 4'($urandom_range(0, 9));
    it.delay_ms          = ($urandom_range(3) == 0) ? 16'($urandom)
                                                    : 16'($urandom_range(0, 400));
    it.use_default_delay = 1'($urandom_range(1));
    it.next_state        = ($urandom_range(9) == 0) ? 4'($urandom_range(10, 15))
                                                    : 4'($urandom_range(0, 9));
    return it;
  endfunction

  // Let time run, with anode pulses between the ticks
  task automatic run_ticks(input int count);
    repeat (count) begin
      if ($urandom_range(3) == 0) send_item(timed_item(MODE_ANODE_ON));
      else send_item(timed_item(MODE_TICK));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Corner items at the reset brightness: extreme stamps, commands while off,
  // rejected digit, anode while disabled, scroll on from off with zero delay,
  // explicit maximum delay, unknown modes, one with every field at its top value
  task automatic test_corner_items();
    item_t it;
    send_item(corner_item(MODE_TICK, 16'h0000, 16'h0000));
    send_item(corner_item(MODE_TICK, 16'hFFFF, 16'hFFFF));
    send_item(corner_item(MODE_SMOOTH_OFF, 16'hFFFF, 16'hFFFF));
    send_item(corner_item(MODE_SCROLL_OFF, 16'hFFFF, 16'hFFFF));
    it = corner_item(MODE_SET_VALUE, 16'h0010, 16'h0000);
    it.digit_value = 4'd15;
    send_item(it);
    send_item(corner_item(MODE_ANODE_ON, 16'h0020, 16'h0000));
    it = corner_item(MODE_SCROLL_ON, 16'h0030, 16'h0000);
    it.use_default_delay = 1'b1;
    send_item(it);
    send_item(corner_item(MODE_TICK, 16'h0430, 16'h0028));
    it = corner_item(MODE_SET_VALUE, 16'h0440, 16'h0028);
    it.digit_value = DIGIT_MAX;
    send_item(it);
    send_item(corner_item(MODE_SMOOTH_ON, 16'h0450, 16'h0030));
    send_item(corner_item(MODE_ANODE_ON, 16'h0460, 16'h0030));
    send_item(corner_item(MODE_TICK, 16'h0560, 16'h0030));
    send_item(corner_item(MODE_TICK, 16'h0A00, 16'h0090));
    send_item(corner_item(MODE_BLINK, 16'h0A10, 16'h0090));
    send_item(corner_item(MODE_TICK, 16'h0E80, 16'h00C0));
    send_item(corner_item(MODE_NO_BLINK, 16'h0E90, 16'h00C0));
    send_item(corner_item(MODE_SMOOTH_OFF, 16'h0EA0, 16'h00C0));
    it = corner_item(MODE_SCROLL_OFF, 16'h0EB0, 16'h00C0);
    it.delay_ms = 16'hFFFF;
    send_item(it);
    send_item(corner_item(MODE_TICK, 16'h1300, 16'h0100));
    it = corner_item(MODE_SCROLL_BK, 16'h1310, 16'h0100);
    it.next_state = 4'd15;
    send_item(it);
    it = corner_item(MODE_SCROLL_FWD, 16'h1320, 16'h0100);
    it.next_state = ST_NORMAL;
    send_item(it);
    send_item(corner_item(MODE_TICK, 16'h1800, 16'h0140));
    send_item(corner_item(4'd11, 16'h1810, 16'h0140));
    it.mode              = 4'd15;
    it.now_us            = 16'hFFFF;
    it.now_ms            = 16'hFFFF;
    it.digit_value       = 4'd15;
    it.delay_ms          = 16'hFFFF;
    it.use_default_delay = 1'b1;
    it.next_state        = 4'd15;
    send_item(it);
  endtask

  // Effect scenarios with random content, each followed by a run of ticks,
  // under one brightness setting and one idling mix
  task automatic test_effect_sequences(input int count, input logic [4:0] level,
                                       input int tx_pct, input int rx_pct);
    int          stop_at;
    item_t       it;
    logic [63:0] noise;
    settle_pipeline();
    write_max_level(level);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          // Pick a digit, now and then an out-of-range one, and fade it in
          it = timed_item(MODE_SET_VALUE);
          if ($urandom_range(7) == 0) it.digit_value = 4'($urandom_range(10, 15));
          send_item(it);
          send_item(timed_item(MODE_SMOOTH_ON));
        end
        2: send_item(timed_item($urandom_range(1) ? MODE_BLINK : MODE_NO_BLINK));
        3: send_item(timed_item(MODE_SMOOTH_OFF));
        4: send_item(timed_item($urandom_range(1) ? MODE_SCROLL_FWD : MODE_SCROLL_BK));
        5: send_item(timed_item(MODE_SCROLL_ON));
        6: send_item(timed_item(MODE_SCROLL_OFF));
        7: begin
          // Noise: any mode, any field value
          noise = {$urandom, $urandom};
          it = noise[60:0];
          send_item(it);
        end
        default: ;
      endcase
      run_ticks($urandom_range(4, 40));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Report check and receiver stalls
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : report_check
    tube_report_t got;
    tube_report_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (expected_reports.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("report with nothing pending: %h", m_tdata);
        end else begin
          want = expected_reports.pop_front();
          if (got.digit_shown !== want.digit_shown || got.anode_high !== want.anode_high ||
              got.level_now !== want.level_now || got.tube_state !== want.tube_state ||
              got.lit !== want.lit || got.stepped !== want.stepped) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"report %0d: expected digit %0d anode %0b level %0d state %0d",
                        " lit %0b stepped %0b, got digit %0d anode %0b level %0d",
                        " state %0d lit %0b stepped %0b"},
                       reports_seen, want.digit_shown, want.anode_high, want.level_now,
                       want.tube_state, want.lit, want.stepped, got.digit_shown,
                       got.anode_high, got.level_now, got.tube_state, got.lit,
                       got.stepped);
          end
        end
        reports_seen++;
      end
      m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Hang detector: count cycles in which no channel moves anything
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: reset, corners, then bursts from slow receiver to no idling
  // ---------------------------------------------------------------------------
  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    tx_idle_pct = 29;
    rx_idle_pct = 87;
    test_corner_items();
    test_effect_sequences(260, 5'd31, 29, 87);
    test_effect_sequences(260, 5'd0, 87, 29);
    test_effect_sequences(260, 5'($urandom_range(1, 15)), 0, 0);
    test_effect_sequences(270, BRIGHT_RESET, 0, 0);
    settle_pipeline();
    // Anything still queued here never came back
    if (expected_reports.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
